// ===== hw/rtl/circle_circle_intersection_assert.svh =====
// Assertion macros for the circle intersection pipeline.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef CIRCLE_CIRCLE_INTERSECTION_ASSERT_SVH
`define CIRCLE_CIRCLE_INTERSECTION_ASSERT_SVH

// Same-cycle implication.
`define CCI_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CCI_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cci_pkg.sv =====
// Shared widths and request types for the circle intersection pipeline.
// No dependencies.
`default_nettype none

package cci_pkg;

  localparam int CW  = 24;          // coordinate width
  localparam int RW  = CW - 1;      // radius width
  localparam int MW  = CW + 1;      // centre delta magnitude
  localparam int DDW = 2*CW + 2;    // squared distance, any input
  localparam int HW  = 2*CW;        // P-D, D-Q and D when crossing
  localparam int HH  = CW;          // half of HW
  localparam int KW  = 4*CW;        // radicand
  localparam int TW  = 2*CW + 1;    // |L|
  localparam int SQW = 2*CW;        // root
  localparam int SRW = 2*CW + 2;    // root remainder
  localparam int XW  = MW + TW;     // |d|*|L|
  localparam int XSW = MW + SQW;    // |d|*S
  localparam int NW  = 3*CW + 4;    // signed numerator
  localparam int N2W = NW + 1;      // rounded dividend
  localparam int QB  = CW + 2;      // quotient bits
  localparam int D2W = 2*CW + 2;    // divisor 4D
  localparam int NHW = N2W - QB;    // dividend high part

  typedef struct packed {
    logic signed [CW-1:0] first_cx;
    logic signed [CW-1:0] first_cy;
    logic        [RW-1:0] first_radius;
    logic signed [CW-1:0] second_cx;
    logic signed [CW-1:0] second_cy;
    logic        [RW-1:0] second_radius;
  } cci_in_t;

  typedef struct packed {
    logic                 found;
    logic signed [CW-1:0] point_a_x;
    logic signed [CW-1:0] point_a_y;
    logic signed [CW-1:0] point_b_x;
    logic signed [CW-1:0] point_b_y;
  } cci_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/circle_circle_intersection.sv =====
// Circle/circle intersection, fully pipelined; needs cci_pkg and the assert header.
// Throughput: one request per cycle while in_stall_o is low. The datapath holds
// the 48-stage square root and the 26-stage divider.
// An output register plus one skid entry decouple the sides; in_stall_o is registered.
// Reset (async, active low) clears valid bits only; data registers are not reset.
`default_nettype none

module circle_circle_intersection
  import cci_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire cci_in_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output cci_out_t      out_req_o
);

  // stage indices: 0 input, 1 deltas, 2 squares, 3 D, 4 tests, 5 partials,
  // 6 radicand, then root steps, round, mul, combine, sign, sum, dividend,
  // overflow, divide steps, place
  localparam int NL  = 4;
  localparam int NST = 15 + SQW + QB;
  localparam int VW  = CW + 3;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic [MW-1:0] adx;
    logic [MW-1:0] ady;
    logic sx;
    logic sy;
  } geo_t;

  typedef struct packed {
    geo_t g;
    logic [MW-1:0] rs;
    logic [RW-1:0] rd;
    logic [RW-1:0] r1;
    logic [RW-1:0] r2;
  } s1_t;

  typedef struct packed {
    geo_t g;
    logic [2*MW-1:0] dxs;
    logic [2*MW-1:0] dys;
    logic [2*MW-1:0] ps;
    logic [2*RW-1:0] qs;
    logic [2*RW-1:0] r1s;
    logic [2*RW-1:0] r2s;
  } s2_t;

  typedef struct packed {
    geo_t g;
    logic [DDW-1:0]  dd;
    logic [2*MW-1:0] ps;
    logic [2*RW-1:0] qs;
    logic [2*RW-1:0] r1s;
    logic [2*RW-1:0] r2s;
  } s3_t;

  typedef struct packed {
    geo_t g;
    logic found;
    logic [HW-1:0] pm;
    logic [HW-1:0] qm;
    logic [TW-1:0] a;
    logic [2*RW-1:0] r2s;
    logic [HW-1:0] dd;
  } s4_t;

  typedef struct packed {
    geo_t g;
    logic [TW-1:0] t;
    logic sl;
    logic [HW-1:0] dd;
    logic found;
  } side_t;

  typedef struct packed {
    side_t s;
    logic [2*HH-1:0] hh;
    logic [2*HH-1:0] hl;
    logic [2*HH-1:0] lh;
    logic [2*HH-1:0] ll;
  } s5_t;

  typedef struct packed {
    logic [SRW-1:0] rem;
    logic [SQW-1:0] root;
    logic [KW-1:0]  kr;
  } sqst_t;

  typedef struct packed {
    side_t s;
    logic [SQW-1:0] sr;
  } rnd_t;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic [HW-1:0] dd;
    logic found;
  } cmn_t;

  typedef struct packed {
    cmn_t c;
    logic sx;
    logic sy;
    logic sl;
    logic [MW+HH-1:0]       axl;
    logic [MW+TW-HH-1:0]    axh;
    logic [MW+HH-1:0]       ayl;
    logic [MW+TW-HH-1:0]    ayh;
    logic [MW+HH-1:0]       asl;
    logic [MW+SQW-HH-1:0]   ash;
    logic [MW+HH-1:0]       bsl;
    logic [MW+SQW-HH-1:0]   bsh;
  } mul_t;

  typedef struct packed {
    cmn_t c;
    logic sx;
    logic sy;
    logic sl;
    logic [XW-1:0]  xm;
    logic [XW-1:0]  ym;
    logic [XSW-1:0] xs;
    logic [XSW-1:0] ys;
  } cmb_t;

  typedef struct packed {
    cmn_t c;
    logic [NW-1:0] xv;
    logic [NW-1:0] yv;
    logic [NW-1:0] xsv;
    logic [NW-1:0] ysv;
  } sgn_t;

  typedef struct packed {
    cmn_t c;
    logic [NL-1:0][NW-1:0] n;
  } sum_t;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic [D2W-1:0] d2;
    logic found;
  } dvc_t;

  typedef struct packed {
    dvc_t c;
    logic [NL-1:0][N2W-1:0] n2;
    logic [NL-1:0] neg;
  } n2_t;

  typedef struct packed {
    logic [D2W-1:0] rem;
    logic [QB-1:0]  q;
    logic [QB-1:0]  nlo;
    logic over;
    logic neg;
  } dvl_t;

  logic en;
  logic [NST-1:0] vld_q;
  logic tail_vld, take;
  logic out_vld_q, skid_vld_q;
  cci_out_t out_q, skid_q;

  cci_in_t s0_q;
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  sqst_t sq_q [0:SQW];
  side_t sd_q [0:SQW];
  rnd_t rn_d, rn_q;
  mul_t mu_d, mu_q;
  cmb_t cb_d, cb_q;
  sgn_t sg_d, sg_q;
  sum_t su_d, su_q;
  n2_t n2_d, n2_q;
  dvl_t [NL-1:0] dv_q [0:QB];
  dvc_t dc_q [0:QB];
  logic [NL-1:0][CW-1:0] pt;
  cci_out_t pl_d, pl_q;

  // global advance; pipe freezes only while the skid entry is occupied
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= in_req_i;
    end
  end

  // centre deltas as sign and magnitude, radius sum and difference
  always_comb begin
    logic signed [MW-1:0] dx, dy;
    dx = MW'(s0_q.second_cx) - MW'(s0_q.first_cx);
    dy = MW'(s0_q.second_cy) - MW'(s0_q.first_cy);
    s1_d.g.x1  = s0_q.first_cx;
    s1_d.g.y1  = s0_q.first_cy;
    s1_d.g.sx  = dx[MW-1];
    s1_d.g.sy  = dy[MW-1];
    s1_d.g.adx = dx[MW-1] ? MW'(-dx) : MW'(dx);
    s1_d.g.ady = dy[MW-1] ? MW'(-dy) : MW'(dy);
    s1_d.rs    = MW'(s0_q.first_radius) + MW'(s0_q.second_radius);
    s1_d.rd    = (s0_q.first_radius >= s0_q.second_radius) ?
                 s0_q.first_radius - s0_q.second_radius :
                 s0_q.second_radius - s0_q.first_radius;
    s1_d.r1    = s0_q.first_radius;
    s1_d.r2    = s0_q.second_radius;
  end

  always_comb begin
    s2_d.g   = s1_q.g;
    s2_d.dxs = (2*MW)'(s1_q.g.adx) * (2*MW)'(s1_q.g.adx);
    s2_d.dys = (2*MW)'(s1_q.g.ady) * (2*MW)'(s1_q.g.ady);
    s2_d.ps  = (2*MW)'(s1_q.rs) * (2*MW)'(s1_q.rs);
    s2_d.qs  = (2*RW)'(s1_q.rd) * (2*RW)'(s1_q.rd);
    s2_d.r1s = (2*RW)'(s1_q.r1) * (2*RW)'(s1_q.r1);
    s2_d.r2s = (2*RW)'(s1_q.r2) * (2*RW)'(s1_q.r2);
  end

  always_comb begin
    s3_d.g   = s2_q.g;
    s3_d.dd  = DDW'(s2_q.dxs) + DDW'(s2_q.dys);
    s3_d.ps  = s2_q.ps;
    s3_d.qs  = s2_q.qs;
    s3_d.r1s = s2_q.r1s;
    s3_d.r2s = s2_q.r2s;
  end

  // crossing test: (r1+r2)^2 > D > (r1-r2)^2
  always_comb begin
    s4_d.g     = s3_q.g;
    s4_d.found = (DDW'(s3_q.ps) > s3_q.dd) && (s3_q.dd > DDW'(s3_q.qs));
    s4_d.pm    = HW'(DDW'(s3_q.ps) - s3_q.dd);
    s4_d.qm    = HW'(s3_q.dd - DDW'(s3_q.qs));
    s4_d.a     = TW'(s3_q.dd) + TW'(s3_q.r1s);
    s4_d.r2s   = s3_q.r2s;
    s4_d.dd    = HW'(s3_q.dd);
  end

  always_comb begin
    s5_d.s.g     = s4_q.g;
    s5_d.s.dd    = s4_q.dd;
    s5_d.s.found = s4_q.found;
    s5_d.s.sl    = s4_q.a < TW'(s4_q.r2s);
    s5_d.s.t     = s5_d.s.sl ? TW'(s4_q.r2s) - s4_q.a : s4_q.a - TW'(s4_q.r2s);
    s5_d.hh = (2*HH)'(s4_q.pm[HW-1:HH]) * (2*HH)'(s4_q.qm[HW-1:HH]);
    s5_d.hl = (2*HH)'(s4_q.pm[HW-1:HH]) * (2*HH)'(s4_q.qm[HH-1:0]);
    s5_d.lh = (2*HH)'(s4_q.pm[HH-1:0])  * (2*HH)'(s4_q.qm[HW-1:HH]);
    s5_d.ll = (2*HH)'(s4_q.pm[HH-1:0])  * (2*HH)'(s4_q.qm[HH-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      sd_q[0]       <= s5_q.s;
      sq_q[0].rem   <= '0;
      sq_q[0].root  <= '0;
      sq_q[0].kr    <= KW'({s5_q.hh, s5_q.ll}) + (KW'(s5_q.hl) << HH)
                       + (KW'(s5_q.lh) << HH);
    end
  end

  // digit-by-digit square root, one result bit per stage
  for (genvar i = 1; i <= SQW; i++) begin : g_sqrt
    logic [SRW+1:0] cur, trial;
    sqst_t nxt;
    always_comb begin
      cur    = {sq_q[i-1].rem, sq_q[i-1].kr[KW-1 -: 2]};
      trial  = (SRW+2)'({sq_q[i-1].root, 2'b01});
      nxt.kr = sq_q[i-1].kr << 2;
      if (cur >= trial) begin
        nxt.rem  = SRW'(cur - trial);
        nxt.root = {sq_q[i-1].root[SQW-2:0], 1'b1};
      end else begin
        nxt.rem  = SRW'(cur);
        nxt.root = {sq_q[i-1].root[SQW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[i] <= nxt;
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  // round to nearest: up when remainder exceeds root
  always_comb begin
    rn_d.s  = sd_q[SQW];
    rn_d.sr = sq_q[SQW].root + SQW'(sq_q[SQW].rem > SRW'(sq_q[SQW].root));
  end

  always_comb begin
    mu_d.c.x1    = rn_q.s.g.x1;
    mu_d.c.y1    = rn_q.s.g.y1;
    mu_d.c.dd    = rn_q.s.dd;
    mu_d.c.found = rn_q.s.found;
    mu_d.sx  = rn_q.s.g.sx;
    mu_d.sy  = rn_q.s.g.sy;
    mu_d.sl  = rn_q.s.sl;
    mu_d.axl = (MW+HH)'(rn_q.s.g.adx) * (MW+HH)'(rn_q.s.t[HH-1:0]);
    mu_d.axh = (MW+TW-HH)'(rn_q.s.g.adx) * (MW+TW-HH)'(rn_q.s.t[TW-1:HH]);
    mu_d.ayl = (MW+HH)'(rn_q.s.g.ady) * (MW+HH)'(rn_q.s.t[HH-1:0]);
    mu_d.ayh = (MW+TW-HH)'(rn_q.s.g.ady) * (MW+TW-HH)'(rn_q.s.t[TW-1:HH]);
    mu_d.asl = (MW+HH)'(rn_q.s.g.adx) * (MW+HH)'(rn_q.sr[HH-1:0]);
    mu_d.ash = (MW+SQW-HH)'(rn_q.s.g.adx) * (MW+SQW-HH)'(rn_q.sr[SQW-1:HH]);
    mu_d.bsl = (MW+HH)'(rn_q.s.g.ady) * (MW+HH)'(rn_q.sr[HH-1:0]);
    mu_d.bsh = (MW+SQW-HH)'(rn_q.s.g.ady) * (MW+SQW-HH)'(rn_q.sr[SQW-1:HH]);
  end

  always_comb begin
    cb_d.c  = mu_q.c;
    cb_d.sx = mu_q.sx;
    cb_d.sy = mu_q.sy;
    cb_d.sl = mu_q.sl;
    cb_d.xm = (XW'(mu_q.axh) << HH) + XW'(mu_q.axl);
    cb_d.ym = (XW'(mu_q.ayh) << HH) + XW'(mu_q.ayl);
    cb_d.xs = (XSW'(mu_q.ash) << HH) + XSW'(mu_q.asl);
    cb_d.ys = (XSW'(mu_q.bsh) << HH) + XSW'(mu_q.bsl);
  end

  // back to two's complement
  always_comb begin
    sg_d.c   = cb_q.c;
    sg_d.xv  = (cb_q.sx ^ cb_q.sl) ? NW'(0) - NW'(cb_q.xm) : NW'(cb_q.xm);
    sg_d.yv  = (cb_q.sy ^ cb_q.sl) ? NW'(0) - NW'(cb_q.ym) : NW'(cb_q.ym);
    sg_d.xsv = cb_q.sx ? NW'(0) - NW'(cb_q.xs) : NW'(cb_q.xs);
    sg_d.ysv = cb_q.sy ? NW'(0) - NW'(cb_q.ys) : NW'(cb_q.ys);
  end

  always_comb begin
    su_d.c    = sg_q.c;
    su_d.n[0] = sg_q.xv + sg_q.ysv;
    su_d.n[1] = sg_q.yv - sg_q.xsv;
    su_d.n[2] = sg_q.xv - sg_q.ysv;
    su_d.n[3] = sg_q.yv + sg_q.xsv;
  end

  // dividend 2|n| + 2D over divisor 4D gives round-half-away of n/(2D)
  always_comb begin
    logic [N2W-1:0] den, nn;
    den = N2W'(su_q.c.dd) << 1;
    n2_d.c.x1    = su_q.c.x1;
    n2_d.c.y1    = su_q.c.y1;
    n2_d.c.found = su_q.c.found;
    n2_d.c.d2    = D2W'(su_q.c.dd) << 2;
    for (int l = 0; l < NL; l++) begin
      nn = N2W'(signed'(su_q.n[l])) << 1;
      n2_d.neg[l] = su_q.n[l][NW-1];
      n2_d.n2[l]  = su_q.n[l][NW-1] ? den - nn : den + nn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rn_q <= rn_d;
      mu_q <= mu_d;
      cb_q <= cb_d;
      sg_q <= sg_d;
      su_q <= su_d;
      n2_q <= n2_d;
      dc_q[0] <= n2_q.c;
    end
  end

  // quotient overflow check seeds the divider remainder
  for (genvar l = 0; l < NL; l++) begin : g_ovf
    logic [NHW-1:0] hi;
    assign hi = n2_q.n2[l][N2W-1:QB];
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[0][l].over <= hi >= NHW'(n2_q.c.d2);
        dv_q[0][l].rem  <= D2W'(hi);
        dv_q[0][l].nlo  <= n2_q.n2[l][QB-1:0];
        dv_q[0][l].q    <= '0;
        dv_q[0][l].neg  <= n2_q.neg[l];
      end
    end
  end

  // restoring division, one quotient bit per stage in each lane
  for (genvar i = 1; i <= QB; i++) begin : g_div
    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [D2W:0] cur;
      dvl_t nxt;
      always_comb begin
        cur      = {dv_q[i-1][l].rem, dv_q[i-1][l].nlo[QB-1]};
        nxt      = dv_q[i-1][l];
        nxt.nlo  = dv_q[i-1][l].nlo << 1;
        if (cur >= (D2W+1)'(dc_q[i-1].d2)) begin
          nxt.rem = D2W'(cur - (D2W+1)'(dc_q[i-1].d2));
          nxt.q   = {dv_q[i-1][l].q[QB-2:0], 1'b1};
        end else begin
          nxt.rem = D2W'(cur);
          nxt.q   = {dv_q[i-1][l].q[QB-2:0], 1'b0};
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_q[i][l] <= nxt;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dc_q[i] <= dc_q[i-1];
      end
    end
  end

  // clamp offset, add to centre, saturate to coordinate range
  for (genvar l = 0; l < NL; l++) begin : g_place
    logic [QB-1:0] lim, mag;
    logic [VW-1:0] v;
    logic signed [CW-1:0] base;
    always_comb begin
      lim  = QB'(1) << (CW + 1);
      base = (l % 2 == 0) ? dc_q[QB].x1 : dc_q[QB].y1;
      mag  = (dv_q[QB][l].over || (dv_q[QB][l].q > lim)) ? lim : dv_q[QB][l].q;
      v    = dv_q[QB][l].neg ? VW'(base) - VW'(mag) : VW'(base) + VW'(mag);
      if (!dc_q[QB].found) begin
        pt[l] = '0;
      end else if ((&v[VW-1:CW-1]) || !(|v[VW-1:CW-1])) begin
        pt[l] = v[CW-1:0];
      end else if (v[VW-1]) begin
        pt[l] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        pt[l] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_comb begin
    pl_d.found     = dc_q[QB].found;
    pl_d.point_a_x = pt[0];
    pl_d.point_a_y = pt[1];
    pl_d.point_b_x = pt[2];
    pl_d.point_b_y = pt[3];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pl_q <= pl_d;
    end
  end

  // output register with one skid entry
  assign tail_vld = en && vld_q[NST-1];
  assign take     = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (take) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= tail_vld;
      end
    end else if (tail_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_vld_q ? skid_q : pl_q;
    end else if (tail_vld) begin
      skid_q <= pl_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

  `include "circle_circle_intersection_assert.svh"

  `CCI_IMPLY(a_skid_behind_out, skid_vld_q, out_vld_q, "skid full with empty output")
  `CCI_NEXT(a_stall_to_skid, out_vld_q && out_stall_i && vld_q[NST-1] && !skid_vld_q, skid_vld_q, "held tail request not parked in skid")
  `CCI_NEXT(a_freeze, skid_vld_q, $stable(vld_q), "pipe advanced while skid full")
  `CCI_IMPLY(a_miss_zero, out_vld_q && !out_q.found, out_q.point_a_x == '0 && out_q.point_a_y == '0 && out_q.point_b_x == '0 && out_q.point_b_y == '0, "miss with non-zero point")

endmodule

`default_nettype wire

// ===== tb/tb_circle_circle_intersection.sv =====
// Testbench for circle_circle_intersection: drives circle pairs, predicts crossing points.
// Depends on cci_pkg and the circle_circle_intersection RTL.
`default_nettype none

module tb_circle_circle_intersection;
  import cci_pkg::*;

  localparam int LATENCY = 89;
  localparam int WATCHDOG_LIMIT = 20000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  cci_in_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  cci_out_t out_req_o;

  circle_circle_intersection dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_req_o(out_req_o)
  );

  always #6 clk_i = ~clk_i;

  cci_out_t crossing_q[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       hold_off = 1'b0;   // long receiver stall requested
  int       hold_len = 0;
  bit       stall_random = 1'b1;

  // Nearest integer to sqrt(k), k below 2^108; bitwise root then round up if
  // the remainder exceeds the root.
  function automatic logic [191:0] root_nearest(logic [191:0] k);
    logic [191:0] res, cand;
    res = '0;
    for (int b = 2*CW + 5; b >= 0; b--) begin
      cand = res | (192'd1 << b);
      if (cand * cand <= k) res = cand;
    end
    if (k - res * res > res) res = res + 1;
    return res;
  endfunction

  // base + num/den, rounded half away from zero, magnitude clamped, then
  // saturated to the coordinate range.
  function automatic logic signed [CW-1:0] place_point(longint base, logic [191:0] mag,
                                                       bit neg, logic [191:0] den);
    logic [191:0] q;
    longint v, hi, lo;
    q = (2 * mag + den) / (2 * den);
    if (q > (192'd1 << (CW + 1))) q = 192'd1 << (CW + 1);
    v = neg ? base - longint'(q[63:0]) : base + longint'(q[63:0]);
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -(longint'(1) << (CW - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  // Signed add of sign/magnitude pairs.
  function automatic void sm_add(input logic [191:0] am, input bit an, input logic [191:0] bm,
                                 input bit bn, output logic [191:0] rm, output bit rn);
    if (an == bn) begin
      rm = am + bm; rn = an;
    end else if (am >= bm) begin
      rm = am - bm; rn = an;
    end else begin
      rm = bm - am; rn = bn;
    end
  endfunction

  function automatic cci_out_t predict_crossing(cci_in_t c);
    cci_out_t r;
    longint x1, y1, x2, y2, dx, dy, r1, r2;
    logic [191:0] adx, ady, dist2, p, q, s, a, b, l, x, y, xs, ys, den, m;
    bit sx, sy, sl, n;
    r = '0;
    x1 = c.first_cx; y1 = c.first_cy; x2 = c.second_cx; y2 = c.second_cy;
    r1 = c.first_radius; r2 = c.second_radius;
    dx = x2 - x1; dy = y2 - y1;
    sx = dx < 0; sy = dy < 0;
    adx = sx ? -dx : dx;
    ady = sy ? -dy : dy;
    dist2 = adx * adx + ady * ady;
    p = (r1 + r2) * (r1 + r2);
    q = (r1 - r2) * (r1 - r2);
    if (!(p > dist2 && dist2 > q)) return r;
    p = p - dist2;
    q = dist2 - q;
    s = root_nearest(p * q);
    a = r1 * r1 + dist2;
    b = r2 * r2;
    if (a >= b) begin
      l = a - b; sl = 1'b0;
    end else begin
      l = b - a; sl = 1'b1;
    end
    x = adx * l; y = ady * l; xs = adx * s; ys = ady * s;
    den = 2 * dist2;
    r.found = 1'b1;
    sm_add(x, sx ^ sl, ys, sy, m, n);   r.point_a_x = place_point(x1, m, n, den);
    sm_add(y, sy ^ sl, xs, !sx, m, n);  r.point_a_y = place_point(y1, m, n, den);
    sm_add(x, sx ^ sl, ys, !sy, m, n);  r.point_b_x = place_point(x1, m, n, den);
    sm_add(y, sy ^ sl, xs, sx, m, n);   r.point_b_y = place_point(y1, m, n, den);
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Offer one request and hold it until accepted; prediction at acceptance.
  // Valid only drops for a gap, so back-to-back requests keep it high.
  task automatic send_request(cci_in_t c, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    crossing_q.push_back(predict_crossing(c));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (crossing_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic cci_in_t make_pair(longint x1, longint y1, longint r1,
                                        longint x2, longint y2, longint r2);
    cci_in_t c;
    c.first_cx = x1[CW-1:0]; c.first_cy = y1[CW-1:0]; c.first_radius = r1[RW-1:0];
    c.second_cx = x2[CW-1:0]; c.second_cy = y2[CW-1:0]; c.second_radius = r2[RW-1:0];
    return c;
  endfunction

  // Circle pairs near crossing: each axis delta of the second centre within the radius sum, mostly small scale.
  function automatic cci_in_t crossing_pair();
    int sc;
    longint x1, y1, r1, r2, dx, dy;
    sc = ($urandom_range(0, 9) == 0) ? 22 : $urandom_range(4, 16);
    x1 = $signed($urandom_range(0, 2**24 - 1) << 8) >>> 8;
    y1 = $signed($urandom_range(0, 2**24 - 1) << 8) >>> 8;
    r1 = $urandom_range(1, 2**sc);
    r2 = $urandom_range(1, 2**sc);
    dx = longint'($urandom_range(0, 2 * (r1 + r2))) - (r1 + r2);
    dy = longint'($urandom_range(0, 2 * (r1 + r2))) - (r1 + r2);
    return make_pair(x1, y1, r1, x1 + dx, y1 + dy, r2);
  endfunction

  function automatic cci_in_t noise_pair();
    cci_in_t c;
    c.first_cx = CW'($urandom); c.first_cy = CW'($urandom); c.first_radius = RW'($urandom);
    c.second_cx = CW'($urandom); c.second_cy = CW'($urandom);
    c.second_radius = RW'($urandom);
    return c;
  endfunction

  task automatic test_directed();
    longint mx, mn, mr;
    mx = 8388607; mn = -8388608; mr = 8388607;
    send_request(make_pair(0, 0, 1280, 1536, 0, 1024), 0);       // plain crossing
    send_request(make_pair(0, 0, 256, 1024, 0, 256), 0);         // apart
    send_request(make_pair(0, 0, 2560, 256, 0, 256), 0);         // nested
    send_request(make_pair(0, 0, 512, 1024, 0, 512), 0);         // outer tangent
    send_request(make_pair(0, 0, 1024, 512, 0, 512), 0);         // inner tangent
    send_request(make_pair(100, -100, 700, 100, -100, 700), 0);  // coincident
    send_request(make_pair(5, 5, 0, 5, 5, 0), 0);                // zero distance, zero radii
    send_request(make_pair(0, 0, 256, 1000, 0, 1100), 0);        // foot behind first centre
    send_request(make_pair(0, 0, 300, -200, -300, 400), 0);      // negative deltas
    send_request(make_pair(mx, mx, mr, mx - 1000, mx, mr), 0);   // saturate high
    send_request(make_pair(mn, mn, mr, mn + 1000, mn, mr), 0);   // saturate low
    send_request(make_pair(mn, mx, mr, mx, mn, mr), 0);          // extreme deltas
    send_request(make_pair(mx, mn, mr, mn, mx, mr), 0);
    send_request(make_pair(0, 0, mr, 1, 1, mr - 1), 0);
    send_request(make_pair(mn, mn, 0, mx, mx, mr), 0);
    send_request(make_pair(-1, -1, 1, 0, 0, 1), 0);              // smallest crossing
    send_request(make_pair(0, 0, mr, 0, 256, mr), 0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_request(($urandom_range(0, 9) < 8) ? crossing_pair() : noise_pair(), 1);
  endtask

  // Receiver holds off while the sender keeps offering, so the pipe backs up.
  task automatic test_backpressure();
    hold_len = 400;
    hold_off = 1'b1;
    for (int i = 0; i < 150; i++) send_request(crossing_pair(), 0);
    wait_drained();
    wait (!hold_off);
  endtask

  task automatic test_no_stall_burst();
    stall_random = 1'b0;
    for (int i = 0; i < 150; i++) send_request(crossing_pair(), 0);
    wait_drained();
    stall_random = 1'b1;
  endtask

  // Receiver stall: random gaps, or one long counted hold-off on request.
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        for (n = 0; n < hold_len; n++) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_off = 1'b0;
      end else if (stall_random) begin
        n = gap_len();
        if (n != 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
          out_stall_i <= 1'b0;
          repeat ($urandom_range(0, 4)) @(posedge clk_i);
        end
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (crossing_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_req_o);
      end else begin
        cci_out_t e;
        e = crossing_q.pop_front();
        if (out_req_o.found !== e.found || out_req_o.point_a_x !== e.point_a_x ||
            out_req_o.point_a_y !== e.point_a_y || out_req_o.point_b_x !== e.point_b_x ||
            out_req_o.point_b_y !== e.point_b_y) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_req_o);
        end
      end
    end
  end

  // Watchdog: cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(700);
    test_backpressure();
    test_no_stall_burst();
    test_random(650);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && crossing_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cci_pkg.sv
hw/rtl/circle_circle_intersection.sv
tb/tb_circle_circle_intersection.sv
